// ----- rtl/tidc_pkg.sv -----
// ----------------------------------------------------------------------------
// tidc_pkg
// Shared constants, types and codes for the Tomasulo issue and dispatch core.
// ----------------------------------------------------------------------------
package tidc_pkg;

	localparam int NUM_REGS_DEF     = 5;
	localparam int ADD_STATIONS_DEF = 3;
	localparam int MUL_STATIONS_DEF = 2;
	localparam int DATA_WIDTH_DEF   = 32;

	// Width of one field of the external interface.
	localparam int TAG_W  = 3;
	localparam int REG_W  = 3;
	localparam int ACT_W  = 3;
	localparam int IMM_W  = 12;
	localparam int LAT_W  = 4;
	localparam int OUT_W  = 32;

	// Instruction action codes.
	typedef enum logic [ACT_W-1:0] {
		ACT_ADD  = 3'd0,
		ACT_ADDI = 3'd1,
		ACT_SUB  = 3'd2,
		ACT_MUL  = 3'd3,
		ACT_DIV  = 3'd4
	} action_t;

	// Station operation kinds.
	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} kind_t;

	// Configuration register indexes.
	localparam logic CFG_ADD_LAT = 1'b0;
	localparam logic CFG_MUL_LAT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick;       // run writeback, issue and add/mul dispatch
		logic div_start;  // load the divider
		logic div_step;   // one quotient bit
		logic div_done;   // finish the pending divide dispatch
	} tidc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_needed; // this tick dispatches a divide with nonzero divisor
		logic div_last;   // the divider is on its final bit
	} tidc_sts_t;

endpackage

// ----- rtl/tomasulo_issue_dispatch_core_top.sv -----
// ----------------------------------------------------------------------------
// tomasulo_issue_dispatch_core_top
// Tomasulo issue and dispatch core with reservation stations.
//
//   channel   direction  handshake             payload
//   s_axis    in         s_axis_tvalid/tready  tdata: one tick's instruction
//   m_axis    out        m_axis_tvalid/tready  tdata: one tick's result
//   cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A tick's result is registered and valid in the cycle after its transfer in.
// A tick that dispatches a nonzero division first runs the bit-serial divider,
// one quotient bit per cycle. The input is held off while the divider runs and
// while a result waits and the output register cannot take the next one.
// Reset loads the register file with 2*i and clears all stations.
// ----------------------------------------------------------------------------
module tomasulo_issue_dispatch_core_top #(
	parameter int NUM_REGS     = tidc_pkg::NUM_REGS_DEF,
	parameter int ADD_STATIONS = tidc_pkg::ADD_STATIONS_DEF,
	parameter int MUL_STATIONS = tidc_pkg::MUL_STATIONS_DEF,
	parameter int DATA_WIDTH   = tidc_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// instr_valid[0], action[3:1], dest_reg[6:4], src1_reg[9:7],
	// src2_reg[12:10], immediate[24:13], zero fill[31:25]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// issued[0], add_wb_valid[1], add_wb_tag[4:2], add_wb_value[36:5],
	// mul_wb_valid[37], mul_wb_tag[40:38], mul_wb_value[72:41],
	// divide_by_zero[73], idle[74], zero fill[79:75]
	output logic [79:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import tidc_pkg::*;

	tidc_cmd_t cmd;
	tidc_sts_t sts;
	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata[79:75] = '0;

	tidc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_ready(s_axis_tready),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .sts(sts), .cmd(cmd)
	);

	tidc_dp #(
		.NUM_REGS(NUM_REGS), .ADD_STATIONS(ADD_STATIONS),
		.MUL_STATIONS(MUL_STATIONS), .DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_fire(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_lat(cfg_data),
		.instr_valid(s_axis_tdata[0]), .action(s_axis_tdata[3:1]),
		.dest_reg(s_axis_tdata[6:4]), .src1_reg(s_axis_tdata[9:7]),
		.src2_reg(s_axis_tdata[12:10]), .immediate(s_axis_tdata[24:13]),
		.issued(m_axis_tdata[0]), .add_wb_valid(m_axis_tdata[1]),
		.add_wb_tag(m_axis_tdata[4:2]), .add_wb_value(m_axis_tdata[36:5]),
		.mul_wb_valid(m_axis_tdata[37]), .mul_wb_tag(m_axis_tdata[40:38]),
		.mul_wb_value(m_axis_tdata[72:41]), .divide_by_zero(m_axis_tdata[73]),
		.idle(m_axis_tdata[74])
	);

`ifndef SYNTHESIS
	// No new tick is taken while a result is held and not taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted over a held result");

	// A tick without a divide gives its result in the next cycle.
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !sts.div_needed |=> m_axis_tvalid)
		else $error("result missing after tick");

	// The divider runs only between ticks.
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !s_axis_tready)
		else $error("input ready during divide");
`endif

endmodule

// ----- rtl/tidc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tidc_ctrl
// Controller: sequences one tick, runs the bit-serial divider when a tick
// dispatches a division, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module tidc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	output logic                in_ready,
	input  logic                out_ready,
	output logic                out_valid,
	input  tidc_pkg::tidc_sts_t sts,
	output tidc_pkg::tidc_cmd_t cmd
);
	import tidc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	// The output register frees up when its result is taken.
	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;

	always_comb begin
		cmd = '0;
		cmd.tick = in_fire;
		cmd.div_start = in_fire && sts.div_needed;
		cmd.div_step = (state_q == ST_DIV);
		cmd.div_done = (state_q == ST_DIV) && sts.div_last;
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && !sts.div_needed) out_valid <= 1'b1;
					else if (out_ready) out_valid <= 1'b0;
					if (in_fire && sts.div_needed) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (out_ready) out_valid <= 1'b0;
					if (sts.div_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/tidc_dp.sv -----
// ----------------------------------------------------------------------------
// tidc_dp
// Datapath: register file, alias table, reservation stations, the two
// execution units and a bit-serial divider, plus the result register.
// ----------------------------------------------------------------------------
module tidc_dp #(
	parameter int NUM_REGS     = tidc_pkg::NUM_REGS_DEF,
	parameter int ADD_STATIONS = tidc_pkg::ADD_STATIONS_DEF,
	parameter int MUL_STATIONS = tidc_pkg::MUL_STATIONS_DEF,
	parameter int DATA_WIDTH   = tidc_pkg::DATA_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tidc_pkg::tidc_cmd_t           cmd,
	output tidc_pkg::tidc_sts_t           sts,
	input  logic                          cfg_fire,
	input  logic                          cfg_sel,
	input  logic [tidc_pkg::LAT_W-1:0]    cfg_lat,
	input  logic                          instr_valid,
	input  logic [tidc_pkg::ACT_W-1:0]    action,
	input  logic [tidc_pkg::REG_W-1:0]    dest_reg,
	input  logic [tidc_pkg::REG_W-1:0]    src1_reg,
	input  logic [tidc_pkg::REG_W-1:0]    src2_reg,
	input  logic signed [tidc_pkg::IMM_W-1:0] immediate,
	output logic                          issued,
	output logic                          add_wb_valid,
	output logic [tidc_pkg::TAG_W-1:0]    add_wb_tag,
	output logic signed [tidc_pkg::OUT_W-1:0] add_wb_value,
	output logic                          mul_wb_valid,
	output logic [tidc_pkg::TAG_W-1:0]    mul_wb_tag,
	output logic signed [tidc_pkg::OUT_W-1:0] mul_wb_value,
	output logic                          divide_by_zero,
	output logic                          idle
);
	import tidc_pkg::*;

	localparam int NSTAT = ADD_STATIONS + MUL_STATIONS;
	localparam int DW    = DATA_WIDTH;
	localparam int CW    = $clog2(DW + 1);

	typedef logic [DW-1:0]    data_t;
	typedef logic [TAG_W-1:0] tag_t;

	typedef struct packed {
		logic  rdy;
		data_t val;
		tag_t  tag;
	} opnd_t;

	// Architectural and station state.
	data_t regs_q  [NUM_REGS];
	tag_t  alias_q [NUM_REGS];
	logic  busy_q  [NSTAT];
	kind_t kind_q  [NSTAT];
	opnd_t opa_q   [NSTAT];
	opnd_t opb_q   [NSTAT];
	logic [LAT_W-1:0] add_lat_q, mul_lat_q;

	// Execution units.
	logic  au_busy_q, mu_busy_q;
	tag_t  au_tag_q, mu_tag_q;
	logic [LAT_W-1:0] au_cnt_q, mu_cnt_q;
	data_t au_val_q, mu_val_q;

	// Divider state, held while the multi-cycle divide runs.
	data_t dv_rem_q, dv_quo_q, dv_dsr_q;
	logic  dv_neg_q;
	logic [CW-1:0] dv_cnt_q;
	tag_t  dv_tag_q;

	// Writeback this tick.
	logic awb, mwb;
	assign awb = au_busy_q && (au_cnt_q == '0);
	assign mwb = mu_busy_q && (mu_cnt_q == '0);

	// Next-state views after writeback and issue.
	data_t regs_n  [NUM_REGS];
	tag_t  alias_n [NUM_REGS];
	logic  busy_n  [NSTAT];
	kind_t kind_n  [NSTAT];
	opnd_t opa_n   [NSTAT];
	opnd_t opb_n   [NSTAT];
	logic  fresh_n [NSTAT];
	logic  iss;

	function automatic opnd_t bcast(opnd_t o, logic v, tag_t t, data_t d);
		opnd_t r;
		r = o;
		if (v && !o.rdy && o.tag == t) begin
			r.rdy = 1'b1;
			r.val = d;
		end
		return r;
	endfunction

	// Rename one source after this tick's writeback.
	function automatic opnd_t rd_src(logic [REG_W-1:0] r, data_t rv [NUM_REGS],
			tag_t al [NUM_REGS]);
		opnd_t o;
		o = '{rdy: 1'b1, val: '0, tag: '0};
		for (int k = 0; k < NUM_REGS; k++) begin
			if (32'(r) == k + 1) begin
				if (al[k] != '0) begin
					o.rdy = 1'b0;
					o.tag = al[k];
				end else begin
					o.val = rv[k];
				end
			end
		end
		return o;
	endfunction

	logic is_add_act, act_ok;
	int   pos;
	kind_t ikind;
	data_t imm_x;
	always_comb begin
		is_add_act = (action == ACT_ADD) || (action == ACT_ADDI) || (action == ACT_SUB);
		act_ok = instr_valid && (action <= ACT_DIV);
		imm_x = data_t'(signed'(immediate));
		case (action)
			ACT_ADD, ACT_ADDI: ikind = KIND_ADD;
			ACT_SUB:           ikind = KIND_SUB;
			ACT_MUL:           ikind = KIND_MUL;
			default:           ikind = KIND_DIV;
		endcase
		// Writeback: add unit first, then mul unit.
		for (int k = 0; k < NUM_REGS; k++) begin
			regs_n[k]  = regs_q[k];
			alias_n[k] = alias_q[k];
			if (awb && alias_n[k] == au_tag_q) begin
				alias_n[k] = '0;
				regs_n[k]  = au_val_q;
			end
			if (mwb && alias_n[k] == mu_tag_q) begin
				alias_n[k] = '0;
				regs_n[k]  = mu_val_q;
			end
		end
		for (int i = 0; i < NSTAT; i++) begin
			busy_n[i]  = busy_q[i];
			kind_n[i]  = kind_q[i];
			opa_n[i]   = opa_q[i];
			opb_n[i]   = opb_q[i];
			fresh_n[i] = 1'b0;
			if (busy_q[i]) begin
				opa_n[i] = bcast(bcast(opa_q[i], awb, au_tag_q, au_val_q),
					mwb, mu_tag_q, mu_val_q);
				opb_n[i] = bcast(bcast(opb_q[i], awb, au_tag_q, au_val_q),
					mwb, mu_tag_q, mu_val_q);
			end
			if (awb && 32'(au_tag_q) == i + 1) busy_n[i] = 1'b0;
			if (mwb && 32'(mu_tag_q) == i + 1) busy_n[i] = 1'b0;
		end
		// Issue into the first free station of the unit.
		pos = -1;
		if (act_ok) begin
			for (int i = NSTAT - 1; i >= 0; i--) begin
				if (!busy_n[i] && ((is_add_act && i < ADD_STATIONS) ||
						(!is_add_act && i >= ADD_STATIONS)))
					pos = i;
			end
		end
		iss = (pos >= 0);
		for (int i = 0; i < NSTAT; i++) begin
			if (pos == i) begin
				opa_n[i] = rd_src(src1_reg, regs_n, alias_n);
				if (action == ACT_ADDI) opb_n[i] = '{rdy: 1'b1, val: imm_x, tag: '0};
				else opb_n[i] = rd_src(src2_reg, regs_n, alias_n);
				kind_n[i]  = ikind;
				busy_n[i]  = 1'b1;
				fresh_n[i] = 1'b1;
			end
		end
		for (int k = 0; k < NUM_REGS; k++) begin
			if (iss && 32'(dest_reg) == k + 1) alias_n[k] = tag_t'(pos + 1);
		end
	end

	// Dispatch selection: lowest ready station of each idle unit.
	int asel, msel;
	logic au_busy_n, mu_busy_n;
	always_comb begin
		au_busy_n = au_busy_q && !awb;
		mu_busy_n = mu_busy_q && !mwb;
		asel = -1;
		msel = -1;
		for (int i = NSTAT - 1; i >= 0; i--) begin
			if (busy_n[i] && !fresh_n[i] && opa_n[i].rdy && opb_n[i].rdy) begin
				if (i < ADD_STATIONS) asel = i;
				else msel = i;
			end
		end
		if (au_busy_n) asel = -1;
		if (mu_busy_n) msel = -1;
	end

	data_t a_a, a_b, m_a, m_b;
	kind_t a_k, m_k;
	always_comb begin
		a_a = '0; a_b = '0; a_k = KIND_ADD;
		m_a = '0; m_b = '0; m_k = KIND_MUL;
		for (int i = 0; i < NSTAT; i++) begin
			if (asel == i) begin a_a = opa_n[i].val; a_b = opb_n[i].val; a_k = kind_n[i]; end
			if (msel == i) begin m_a = opa_n[i].val; m_b = opb_n[i].val; m_k = kind_n[i]; end
		end
	end

	data_t a_res, m_prod;
	logic  m_div, m_dz;
	assign a_res  = (a_k == KIND_SUB) ? a_a - a_b : a_a + a_b;
	assign m_prod = m_a * m_b;
	assign m_div  = (msel >= 0) && (m_k == KIND_DIV);
	assign m_dz   = m_div && (m_b == '0);
	assign sts.div_needed = m_div && !m_dz;
	assign sts.div_last   = (dv_cnt_q == CW'(1));

	// Divider trial subtract.
	data_t dv_mag_a, dv_mag_b;
	logic [DW:0] dv_sh, dv_diff;
	assign dv_mag_a = m_a[DW-1] ? -m_a : m_a;
	assign dv_mag_b = m_b[DW-1] ? -m_b : m_b;
	assign dv_sh    = {dv_rem_q, dv_quo_q[DW-1]};
	assign dv_diff  = dv_sh - {1'b0, dv_dsr_q};

	data_t dv_q_next, dv_final;
	assign dv_q_next = {dv_quo_q[DW-2:0], !dv_diff[DW]};
	assign dv_final  = dv_neg_q ? -dv_q_next : dv_q_next;

	function automatic logic [LAT_W-1:0] lat0(logic [LAT_W-1:0] l);
		return (l == '0) ? LAT_W'(1) : l;
	endfunction

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_lat_q <= LAT_W'(2);
			mul_lat_q <= LAT_W'(4);
		end else if (cfg_fire) begin
			if (cfg_sel == CFG_ADD_LAT) add_lat_q <= cfg_lat;
			else mul_lat_q <= cfg_lat;
		end
	end

	// Machine state update at each tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) begin
				regs_q[k]  <= data_t'(2 * k);
				alias_q[k] <= '0;
			end
			for (int i = 0; i < NSTAT; i++) begin
				busy_q[i] <= 1'b0;
				kind_q[i] <= KIND_ADD;
				opa_q[i]  <= '0;
				opb_q[i]  <= '0;
			end
			au_busy_q <= 1'b0; au_tag_q <= '0; au_cnt_q <= '0; au_val_q <= '0;
			mu_busy_q <= 1'b0; mu_tag_q <= '0; mu_cnt_q <= '0; mu_val_q <= '0;
			dv_cnt_q  <= '0;
		end else begin
			if (cmd.tick) begin
				regs_q  <= regs_n;
				alias_q <= alias_n;
				busy_q  <= busy_n;
				kind_q  <= kind_n;
				opa_q   <= opa_n;
				opb_q   <= opb_n;
				if (asel >= 0) begin
					au_busy_q <= 1'b1;
					au_tag_q  <= tag_t'(asel + 1);
					au_cnt_q  <= lat0(add_lat_q) - LAT_W'(1);
					au_val_q  <= a_res;
				end else begin
					au_busy_q <= au_busy_n;
					if (awb) begin au_tag_q <= '0; au_val_q <= '0; end
					if (au_cnt_q != '0) au_cnt_q <= au_cnt_q - LAT_W'(1);
				end
				if (msel >= 0) begin
					mu_busy_q <= 1'b1;
					mu_tag_q  <= tag_t'(msel + 1);
					mu_cnt_q  <= lat0(mul_lat_q) - LAT_W'(1);
					mu_val_q  <= m_div ? '0 : m_prod;
				end else begin
					mu_busy_q <= mu_busy_n;
					if (mwb) begin mu_tag_q <= '0; mu_val_q <= '0; end
					if (mu_cnt_q != '0) mu_cnt_q <= mu_cnt_q - LAT_W'(1);
				end
			end
			if (cmd.div_start) dv_cnt_q <= CW'(DW);
			else if (cmd.div_step) dv_cnt_q <= dv_cnt_q - CW'(1);
			if (cmd.div_done) mu_val_q <= dv_final;
		end
	end

	// Divider datapath registers.
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_rem_q <= '0;
			dv_quo_q <= dv_mag_a;
			dv_dsr_q <= dv_mag_b;
			dv_neg_q <= m_a[DW-1] ^ m_b[DW-1];
			dv_tag_q <= tag_t'(msel + 1);
		end else if (cmd.div_step && dv_tag_q != '0) begin
			dv_rem_q <= dv_diff[DW] ? dv_sh[DW-1:0] : dv_diff[DW-1:0];
			dv_quo_q <= dv_q_next;
		end
	end

	// Result register.
	logic any_busy;
	always_comb begin
		any_busy = 1'b0;
		for (int i = 0; i < NSTAT; i++) any_busy = any_busy | busy_n[i];
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			issued         <= iss;
			add_wb_valid   <= awb;
			add_wb_tag     <= awb ? au_tag_q : '0;
			add_wb_value   <= awb ? OUT_W'(signed'(au_val_q)) : '0;
			mul_wb_valid   <= mwb;
			mul_wb_tag     <= mwb ? mu_tag_q : '0;
			mul_wb_value   <= mwb ? OUT_W'(signed'(mu_val_q)) : '0;
			divide_by_zero <= m_dz;
			idle           <= !any_busy;
		end
	end

endmodule
